@@ sv/assert_macros.svh @@
// Assertion helpers for the record adapter checkers.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ sv/tbra_pkg.sv @@
package tbra_pkg;

   localparam int unsigned MAX_BLOCKS = 255;

   // record phase
   localparam logic [2:0] PH_H0   = 3'd0;
   localparam logic [2:0] PH_H1   = 3'd1;
   localparam logic [2:0] PH_H2   = 3'd2;
   localparam logic [2:0] PH_H3   = 3'd3;
   localparam logic [2:0] PH_DESC = 3'd4;
   localparam logic [2:0] PH_TEXT = 3'd5;
   localparam logic [2:0] PH_DONE = 3'd6;

   // error codes
   localparam logic [2:0] ERR_NONE   = 3'd0;
   localparam logic [2:0] ERR_HEADER = 3'd1;
   localparam logic [2:0] ERR_TRUNC  = 3'd2;
   localparam logic [2:0] ERR_GEOM   = 3'd3;
   localparam logic [2:0] ERR_FLAGS  = 3'd4;
   localparam logic [2:0] ERR_UTF8   = 3'd5;
   localparam logic [2:0] ERR_TRAIL  = 3'd6;

   // range class of the next UTF-8 continuation byte
   localparam logic [2:0] CB_NORMAL = 3'd0;
   localparam logic [2:0] CB_LO_A0  = 3'd1;
   localparam logic [2:0] CB_HI_9F  = 3'd2;
   localparam logic [2:0] CB_LO_90  = 3'd3;
   localparam logic [2:0] CB_HI_8F  = 3'd4;

   // descriptor byte positions
   localparam logic [3:0] DESC_COPY_BYTES = 4'd10;
   localparam logic [3:0] DESC_HEIGHT_HI  = 4'd7;
   localparam logic [3:0] DESC_FLAGS_LO   = 4'd10;
   localparam logic [3:0] DESC_FLAGS_HI   = 4'd11;

   localparam logic [3:0] HDR_LAST = 4'd13;

   // configuration register indexes
   localparam logic CSR_IMAGE_WIDTH  = 1'b0;
   localparam logic CSR_IMAGE_HEIGHT = 1'b1;

   localparam logic [9:0] IMAGE_WIDTH_RST  = 10'd528;
   localparam logic [9:0] IMAGE_HEIGHT_RST = 10'd800;

   typedef struct packed {
      logic       valid;
      logic       burst;
      logic [7:0] data;
      logic       present;
      logic       eor;
      logic [2:0] code;
   } result_type;

   function automatic logic [7:0] hdr_byte(input logic [3:0] idx, input logic [9:0] width,
                                           input logic [9:0] height, input logic [7:0] count);
      logic [7:0] val;
      val = 8'd0;
      case (idx)
         4'd0:    val = 8'd1;
         4'd6:    val = width[7:0];
         4'd7:    val = {6'd0, width[9:8]};
         4'd8:    val = height[7:0];
         4'd9:    val = {6'd0, height[9:8]};
         4'd10:   val = count;
         default: val = 8'd0;
      endcase
      return val;
   endfunction

endpackage

@@ sv/tbra_step.sv @@
module tbra_step (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     proc_valid,
   input  logic [7:0]               in_byte,
   input  logic                     in_last,
   input  logic [9:0]               image_width,
   input  logic [9:0]               image_height,
   output tbra_pkg::result_type     res
);

   logic [2:0]  phase_ff, phase_in;
   logic [3:0]  bif_ff, bif_in;
   logic [7:0]  blocks_ff, blocks_in;
   logic [15:0] fields_ff [5];
   logic [15:0] fields_in [5];
   logic [15:0] text_ff, text_in;
   logic [1:0]  pend_ff, pend_in;
   logic [2:0]  cb_ff, cb_in;
   logic [2:0]  err_ff, err_in;

   logic        emit_one, emit_hdr;
   logic [2:0]  fidx;

   // geometry, evaluated on the height high byte
   logic [15:0] img_w, img_h, h_new, room_x, room_y;
   logic        geom_bad;

   assign img_w  = {6'd0, image_width};
   assign img_h  = {6'd0, image_height};
   assign h_new  = {in_byte, fields_ff[3][7:0]};
   assign room_x = img_w - fields_ff[0];
   assign room_y = img_h - fields_ff[1];
   assign geom_bad = (fields_ff[2] == 16'd0) || (h_new == 16'd0) ||
                     (fields_ff[0] >= img_w) || (fields_ff[1] >= img_h) ||
                     (fields_ff[2] > room_x) || (h_new > room_y);

   assign fidx = bif_ff[3:1];

   // UTF-8 decoder step
   logic       utf_ok;
   logic [1:0] utf_pend;
   logic [2:0] utf_cb;
   logic [7:0] cb_lo, cb_hi;

   always_comb begin
      cb_lo    = 8'h80;
      cb_hi    = 8'hbf;
      utf_ok   = 1'b1;
      utf_pend = 2'd0;
      utf_cb   = tbra_pkg::CB_NORMAL;
      if (pend_ff != 2'd0) begin
         case (cb_ff)
            tbra_pkg::CB_LO_A0: cb_lo = 8'ha0;
            tbra_pkg::CB_HI_9F: cb_hi = 8'h9f;
            tbra_pkg::CB_LO_90: cb_lo = 8'h90;
            tbra_pkg::CB_HI_8F: cb_hi = 8'h8f;
            default:            cb_lo = 8'h80;
         endcase
         utf_ok   = (in_byte >= cb_lo) && (in_byte <= cb_hi);
         utf_pend = pend_ff - 2'd1;
      end else if (in_byte == 8'h00) begin
         utf_ok = 1'b0;
      end else if (in_byte < 8'h80) begin
         utf_ok = 1'b1;
      end else if (in_byte >= 8'hc2 && in_byte <= 8'hdf) begin
         utf_pend = 2'd1;
      end else if (in_byte >= 8'he0 && in_byte <= 8'hef) begin
         utf_pend = 2'd2;
         if (in_byte == 8'he0) utf_cb = tbra_pkg::CB_LO_A0;
         if (in_byte == 8'hed) utf_cb = tbra_pkg::CB_HI_9F;
      end else if (in_byte >= 8'hf0 && in_byte <= 8'hf4) begin
         utf_pend = 2'd3;
         if (in_byte == 8'hf0) utf_cb = tbra_pkg::CB_LO_90;
         if (in_byte == 8'hf4) utf_cb = tbra_pkg::CB_HI_8F;
      end else begin
         utf_ok = 1'b0;
      end
   end

   always_comb begin
      phase_in  = phase_ff;
      bif_in    = bif_ff;
      blocks_in = blocks_ff;
      fields_in = fields_ff;
      text_in   = text_ff;
      pend_in   = pend_ff;
      cb_in     = cb_ff;
      err_in    = err_ff;
      emit_one  = 1'b0;
      emit_hdr  = 1'b0;
      if (proc_valid) begin
         if (err_ff == tbra_pkg::ERR_NONE) begin
            unique case (phase_ff)
               tbra_pkg::PH_H0: begin
                  fields_in[0] = {8'd0, in_byte};
                  phase_in     = tbra_pkg::PH_H1;
               end
               tbra_pkg::PH_H1: begin
                  fields_in[0][15:8] = in_byte;
                  phase_in           = tbra_pkg::PH_H2;
               end
               tbra_pkg::PH_H2: begin
                  if (in_byte != 8'd0) err_in = tbra_pkg::ERR_HEADER;
                  else phase_in = tbra_pkg::PH_H3;
               end
               tbra_pkg::PH_H3: begin
                  if (in_byte != 8'd0 || fields_ff[0] > 16'(tbra_pkg::MAX_BLOCKS)) begin
                     err_in = tbra_pkg::ERR_HEADER;
                  end else begin
                     emit_hdr  = 1'b1;
                     blocks_in = fields_ff[0][7:0];
                     phase_in  = (fields_ff[0][7:0] == 8'd0) ? tbra_pkg::PH_DONE
                                                              : tbra_pkg::PH_DESC;
                     bif_in    = 4'd0;
                  end
               end
               tbra_pkg::PH_DESC: begin
                  if (bif_ff < tbra_pkg::DESC_COPY_BYTES) begin
                     if (bif_ff[0]) fields_in[fidx][15:8] = in_byte;
                     else fields_in[fidx] = {8'd0, in_byte};
                     if (bif_ff == tbra_pkg::DESC_HEIGHT_HI && geom_bad) begin
                        err_in = tbra_pkg::ERR_GEOM;
                     end else begin
                        emit_one = 1'b1;
                        bif_in   = bif_ff + 4'd1;
                     end
                  end else if (bif_ff == tbra_pkg::DESC_FLAGS_LO) begin
                     if (in_byte[7:1] != 7'd0) err_in = tbra_pkg::ERR_FLAGS;
                     else bif_in = tbra_pkg::DESC_FLAGS_HI;
                  end else begin
                     if (in_byte != 8'd0) begin
                        err_in = tbra_pkg::ERR_FLAGS;
                     end else begin
                        text_in = fields_ff[4];
                        pend_in = 2'd0;
                        cb_in   = tbra_pkg::CB_NORMAL;
                        bif_in  = 4'd0;
                        if (fields_ff[4] == 16'd0) begin
                           blocks_in = blocks_ff - 8'd1;
                           phase_in  = (blocks_ff != 8'd1) ? tbra_pkg::PH_DESC
                                                            : tbra_pkg::PH_DONE;
                        end else begin
                           phase_in = tbra_pkg::PH_TEXT;
                        end
                     end
                  end
               end
               tbra_pkg::PH_TEXT: begin
                  if (!utf_ok) begin
                     err_in = tbra_pkg::ERR_UTF8;
                  end else begin
                     emit_one = 1'b1;
                     pend_in  = utf_pend;
                     cb_in    = utf_cb;
                     text_in  = text_ff - 16'd1;
                     if (text_ff == 16'd1) begin
                        if (utf_pend != 2'd0) begin
                           err_in = tbra_pkg::ERR_UTF8;
                        end else begin
                           blocks_in = blocks_ff - 8'd1;
                           bif_in    = 4'd0;
                           phase_in  = (blocks_ff != 8'd1) ? tbra_pkg::PH_DESC
                                                            : tbra_pkg::PH_DONE;
                        end
                     end
                  end
               end
               default: err_in = tbra_pkg::ERR_TRAIL;
            endcase
         end
         if (in_last) begin
            if (err_in == tbra_pkg::ERR_NONE && phase_in != tbra_pkg::PH_DONE) begin
               err_in = tbra_pkg::ERR_TRUNC;
            end
         end
      end
   end

   always_comb begin
      res.valid   = proc_valid && (emit_one || emit_hdr || in_last);
      res.burst   = emit_hdr;
      res.data    = emit_hdr ? fields_ff[0][7:0] : (emit_one ? in_byte : 8'd0);
      res.present = emit_one || emit_hdr;
      res.eor     = in_last;
      res.code    = err_in;
   end

   always_ff @(posedge clock) begin
      if (reset || (proc_valid && in_last)) begin
         phase_ff  <= tbra_pkg::PH_H0;
         bif_ff    <= 4'd0;
         blocks_ff <= 8'd0;
         for (int i = 0; i < 5; i++) fields_ff[i] <= 16'd0;
         text_ff   <= 16'd0;
         pend_ff   <= 2'd0;
         cb_ff     <= tbra_pkg::CB_NORMAL;
         err_ff    <= tbra_pkg::ERR_NONE;
      end else begin
         phase_ff  <= phase_in;
         bif_ff    <= bif_in;
         blocks_ff <= blocks_in;
         fields_ff <= fields_in;
         text_ff   <= text_in;
         pend_ff   <= pend_in;
         cb_ff     <= cb_in;
         err_ff    <= err_in;
      end
   end

endmodule

@@ sv/text_block_record_adapter_core.sv @@
// Page record adapter: checks a page record byte by byte and converts it.
// Request channel (req_valid / req_stall): one raw record byte per
// transaction, req_in_last marking the record's final byte.
// Response channel (rsp_valid / rsp_stall): at most one converted byte per
// transaction; the last transaction of a record has rsp_end_of_record set and
// carries rsp_record_ok and rsp_error_code. Output with record_ok low is to
// be discarded by the receiver.
// Configuration: csr_wr_en writes csr_wdata into image width (index 0) or
// image height (index 1); write only while the block is idle.
// A response is registered: it appears in the cycle after its request byte is
// processed. Throughput: one request byte per cycle while the output is not
// stalled, except the fourth header byte, which produces a 14-byte page header
// and holds the output register until all of its bytes are taken.
// A one-entry skid register takes a byte while a response waits; with the
// response stalled it fills and req_stall rises until the output frees up.
// Reset (synchronous) empties both stages, clears record state and sets the
// image size to 528 x 800.
module text_block_record_adapter_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_in_byte,
   input  logic        req_in_last,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_out_byte,
   output logic        rsp_byte_present,
   output logic        rsp_end_of_record,
   output logic        rsp_record_ok,
   output logic [2:0]  rsp_error_code,
   input  logic        csr_wr_en,
   input  logic        csr_index,
   input  logic [9:0]  csr_wdata
);

   logic [9:0] width_ff, height_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= tbra_pkg::IMAGE_WIDTH_RST;
         height_ff <= tbra_pkg::IMAGE_HEIGHT_RST;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            tbra_pkg::CSR_IMAGE_WIDTH:  width_ff  <= csr_wdata;
            tbra_pkg::CSR_IMAGE_HEIGHT: height_ff <= csr_wdata;
            default:                    width_ff  <= width_ff;
         endcase
      end
   end

   logic       skid_valid_ff, skid_valid_in;
   logic [7:0] skid_byte_ff;
   logic       skid_last_ff;

   logic       job_valid_ff, job_valid_in;
   logic       job_burst_ff;
   logic [3:0] job_idx_ff;
   logic [7:0] job_byte_ff;
   logic       job_present_ff;
   logic       job_eor_ff;
   logic [2:0] job_code_ff;

   logic       rsp_take, job_done, job_free, proc_valid, out_eor;
   logic [7:0] src_byte;
   logic       src_last;
   tbra_pkg::result_type res;

   assign rsp_take   = job_valid_ff && !rsp_stall;
   assign job_done   = rsp_take && (!job_burst_ff || job_idx_ff == tbra_pkg::HDR_LAST);
   assign job_free   = !job_valid_ff || job_done;
   assign proc_valid = job_free && (skid_valid_ff || req_valid);
   assign src_byte   = skid_valid_ff ? skid_byte_ff : req_in_byte;
   assign src_last   = skid_valid_ff ? skid_last_ff : req_in_last;
   assign req_stall  = skid_valid_ff;

   assign skid_valid_in = skid_valid_ff ? !job_free : (req_valid && !job_free);
   assign job_valid_in  = (proc_valid && res.valid) || (job_valid_ff && !job_done);

   tbra_step u_step (
      .clock        (clock),
      .reset        (reset),
      .proc_valid   (proc_valid),
      .in_byte      (src_byte),
      .in_last      (src_last),
      .image_width  (width_ff),
      .image_height (height_ff),
      .res          (res)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         skid_valid_ff <= 1'b0;
         job_valid_ff  <= 1'b0;
      end else begin
         skid_valid_ff <= skid_valid_in;
         job_valid_ff  <= job_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (!skid_valid_ff) begin
         skid_byte_ff <= req_in_byte;
         skid_last_ff <= req_in_last;
      end
      if (proc_valid && res.valid) begin
         job_burst_ff   <= res.burst;
         job_idx_ff     <= 4'd0;
         job_byte_ff    <= res.data;
         job_present_ff <= res.present;
         job_eor_ff     <= res.eor;
         job_code_ff    <= res.code;
      end else if (rsp_take && job_burst_ff && job_idx_ff != tbra_pkg::HDR_LAST) begin
         job_idx_ff <= job_idx_ff + 4'd1;
      end
   end

   assign out_eor = job_eor_ff && (!job_burst_ff || job_idx_ff == tbra_pkg::HDR_LAST);

   assign rsp_valid         = job_valid_ff;
   assign rsp_out_byte      = job_burst_ff
                              ? tbra_pkg::hdr_byte(job_idx_ff, width_ff, height_ff, job_byte_ff)
                              : job_byte_ff;
   assign rsp_byte_present  = job_present_ff;
   assign rsp_end_of_record = out_eor;
   assign rsp_record_ok     = out_eor && (job_code_ff == tbra_pkg::ERR_NONE);
   assign rsp_error_code    = out_eor ? job_code_ff : tbra_pkg::ERR_NONE;

endmodule

@@ sv/tbra_checker.sv @@
`include "assert_macros.svh"

module tbra_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [7:0]  rsp_out_byte,
   input logic        rsp_byte_present,
   input logic        rsp_end_of_record,
   input logic        rsp_record_ok,
   input logic [2:0]  rsp_error_code
);

   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_out_byte) && $stable(rsp_end_of_record), "stalled response changed")

   `ASSERT_IMPLIES(a_ok_matches_code, clock, reset, rsp_valid && rsp_end_of_record, rsp_record_ok == (rsp_error_code == tbra_pkg::ERR_NONE), "record_ok disagrees with error_code")

   `ASSERT_IMPLIES(a_status_only_at_end, clock, reset, rsp_valid && !rsp_end_of_record, !rsp_record_ok && rsp_error_code == tbra_pkg::ERR_NONE, "status shown before end of record")

   `ASSERT_IMPLIES(a_empty_only_at_end, clock, reset, rsp_valid && !rsp_byte_present, rsp_end_of_record && rsp_out_byte == 8'd0, "empty transaction not at end of record")

   `ASSERT_IMPLIES(a_code_range, clock, reset, rsp_valid, rsp_error_code <= tbra_pkg::ERR_TRAIL, "error code out of range")

endmodule

bind text_block_record_adapter_core tbra_checker u_tbra_checker (.*);

@@ test/tb.sv @@
`timescale 1ns / 100ps

module tb;

   typedef logic [7:0] byte_q_type[$];

   typedef struct packed {
      logic [7:0] data;
      logic       present;
      logic       eor;
      logic       ok;
      logic [2:0] code;
   } page_out_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   logic [7:0] req_in_byte = 8'd0;
   logic       req_in_last = 1'b0;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic [7:0] rsp_out_byte;
   logic       rsp_byte_present;
   logic       rsp_end_of_record;
   logic       rsp_record_ok;
   logic [2:0] rsp_error_code;
   logic       csr_wr_en = 1'b0;
   logic       csr_index = 1'b0;
   logic [9:0] csr_wdata = 10'd0;

   text_block_record_adapter_core u_top (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_in_byte       (req_in_byte),
      .req_in_last       (req_in_last),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_out_byte      (rsp_out_byte),
      .rsp_byte_present  (rsp_byte_present),
      .rsp_end_of_record (rsp_end_of_record),
      .rsp_record_ok     (rsp_record_ok),
      .rsp_error_code    (rsp_error_code),
      .csr_wr_en         (csr_wr_en),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // predicted adapter state
   logic [9:0]  img_w = tbra_pkg::IMAGE_WIDTH_RST;
   logic [9:0]  img_h = tbra_pkg::IMAGE_HEIGHT_RST;
   logic [2:0]  rec_phase;
   logic [3:0]  field_pos;
   logic [7:0]  blocks_left;
   logic [15:0] desc_field [5];
   logic [15:0] text_left;
   logic [1:0]  utf8_pend;
   logic [2:0]  cont_class;
   logic [2:0]  sticky_err;

   page_out_type converted_q[$];
   int unsigned mismatches = 0;
   int unsigned results_seen = 0;
   int unsigned gap_pct = 15;
   int unsigned stall_pct = 8;
   logic        calm = 1'b0;

   task automatic report_mismatch(input string what);
      mismatches++;
      $display("mismatch: %s", what);
   endtask

   function automatic page_out_type page_byte(input logic [7:0] b, input logic present);
      page_out_type o;
      o.data    = b;
      o.present = present;
      o.eor     = 1'b0;
      o.ok      = 1'b0;
      o.code    = tbra_pkg::ERR_NONE;
      return o;
   endfunction

   task automatic clear_record_state();
      int i;
      rec_phase   = tbra_pkg::PH_H0;
      field_pos   = 4'd0;
      blocks_left = 8'd0;
      for (i = 0; i < 5; i++) desc_field[i] = 16'd0;
      text_left   = 16'd0;
      utf8_pend   = 2'd0;
      cont_class  = tbra_pkg::CB_NORMAL;
      sticky_err  = tbra_pkg::ERR_NONE;
   endtask

   task automatic close_block();
      blocks_left = blocks_left - 8'd1;
      rec_phase   = (blocks_left != 8'd0) ? tbra_pkg::PH_DESC : tbra_pkg::PH_DONE;
      field_pos   = 4'd0;
   endtask

   task automatic adapt_byte(input logic [7:0] b, input logic last);
      page_out_type step_q[$];
      logic [7:0]  hb, lo, hi;
      logic [3:0]  k;
      logic        char_ok;
      int unsigned gx, gy, gw, gh;
      int          i;
      if (sticky_err == tbra_pkg::ERR_NONE) begin
         case (rec_phase)
            tbra_pkg::PH_H0: begin
               desc_field[0] = {8'd0, b};
               rec_phase = tbra_pkg::PH_H1;
            end
            tbra_pkg::PH_H1: begin
               desc_field[0][15:8] = b;
               rec_phase = tbra_pkg::PH_H2;
            end
            tbra_pkg::PH_H2: begin
               if (b != 8'd0) sticky_err = tbra_pkg::ERR_HEADER;
               else rec_phase = tbra_pkg::PH_H3;
            end
            tbra_pkg::PH_H3: begin
               if (b != 8'd0 || desc_field[0] > tbra_pkg::MAX_BLOCKS) begin
                  sticky_err = tbra_pkg::ERR_HEADER;
               end else begin
                  for (i = 0; i <= tbra_pkg::HDR_LAST; i++) begin
                     case (i)
                        0:       hb = 8'd1;
                        6:       hb = img_w[7:0];
                        7:       hb = {6'd0, img_w[9:8]};
                        8:       hb = img_h[7:0];
                        9:       hb = {6'd0, img_h[9:8]};
                        10:      hb = desc_field[0][7:0];
                        default: hb = 8'd0;
                     endcase
                     step_q.push_back(page_byte(hb, 1'b1));
                  end
                  blocks_left = desc_field[0][7:0];
                  rec_phase   = (blocks_left != 8'd0) ? tbra_pkg::PH_DESC : tbra_pkg::PH_DONE;
                  field_pos   = 4'd0;
               end
            end
            tbra_pkg::PH_DESC: begin
               k = field_pos;
               if (k < tbra_pkg::DESC_COPY_BYTES) begin
                  if (k[0]) desc_field[k[3:1]][15:8] = b;
                  else desc_field[k[3:1]] = {8'd0, b};
                  gx = desc_field[0];
                  gy = desc_field[1];
                  gw = desc_field[2];
                  gh = desc_field[3];
                  if (k == tbra_pkg::DESC_HEIGHT_HI
                        && (gw == 0 || gh == 0 || gx >= img_w || gy >= img_h
                        || gw > img_w - gx || gh > img_h - gy)) begin
                     sticky_err = tbra_pkg::ERR_GEOM;
                  end else begin
                     step_q.push_back(page_byte(b, 1'b1));
                     field_pos = k + 4'd1;
                  end
               end else if (k == tbra_pkg::DESC_FLAGS_LO) begin
                  if (b[7:1] != 7'd0) sticky_err = tbra_pkg::ERR_FLAGS;
                  else field_pos = tbra_pkg::DESC_FLAGS_HI;
               end else begin
                  if (b != 8'd0) begin
                     sticky_err = tbra_pkg::ERR_FLAGS;
                  end else begin
                     text_left  = desc_field[4];
                     utf8_pend  = 2'd0;
                     cont_class = tbra_pkg::CB_NORMAL;
                     if (text_left == 16'd0) begin
                        close_block();
                     end else begin
                        rec_phase = tbra_pkg::PH_TEXT;
                        field_pos = 4'd0;
                     end
                  end
               end
            end
            tbra_pkg::PH_TEXT: begin
               char_ok = 1'b1;
               if (utf8_pend != 2'd0) begin
                  lo = 8'h80;
                  hi = 8'hbf;
                  case (cont_class)
                     tbra_pkg::CB_LO_A0: lo = 8'ha0;
                     tbra_pkg::CB_HI_9F: hi = 8'h9f;
                     tbra_pkg::CB_LO_90: lo = 8'h90;
                     tbra_pkg::CB_HI_8F: hi = 8'h8f;
                     default: ;
                  endcase
                  if (b < lo || b > hi) begin
                     char_ok = 1'b0;
                  end else begin
                     cont_class = tbra_pkg::CB_NORMAL;
                     utf8_pend  = utf8_pend - 2'd1;
                  end
               end else if (b == 8'h00) begin
                  char_ok = 1'b0;
               end else if (b >= 8'h80) begin
                  cont_class = tbra_pkg::CB_NORMAL;
                  if (b >= 8'hc2 && b <= 8'hdf) begin
                     utf8_pend = 2'd1;
                  end else if (b >= 8'he0 && b <= 8'hef) begin
                     utf8_pend = 2'd2;
                     if (b == 8'he0) cont_class = tbra_pkg::CB_LO_A0;
                     if (b == 8'hed) cont_class = tbra_pkg::CB_HI_9F;
                  end else if (b >= 8'hf0 && b <= 8'hf4) begin
                     utf8_pend = 2'd3;
                     if (b == 8'hf0) cont_class = tbra_pkg::CB_LO_90;
                     if (b == 8'hf4) cont_class = tbra_pkg::CB_HI_8F;
                  end else begin
                     char_ok = 1'b0;
                  end
               end
               if (!char_ok) begin
                  sticky_err = tbra_pkg::ERR_UTF8;
               end else begin
                  step_q.push_back(page_byte(b, 1'b1));
                  text_left = text_left - 16'd1;
                  if (text_left == 16'd0) begin
                     if (utf8_pend != 2'd0) sticky_err = tbra_pkg::ERR_UTF8;
                     else close_block();
                  end
               end
            end
            default: sticky_err = tbra_pkg::ERR_TRAIL;
         endcase
      end
      if (last) begin
         if (sticky_err == tbra_pkg::ERR_NONE && rec_phase != tbra_pkg::PH_DONE)
            sticky_err = tbra_pkg::ERR_TRUNC;
         if (step_q.size() == 0) step_q.push_back(page_byte(8'd0, 1'b0));
         step_q[step_q.size()-1].eor  = 1'b1;
         step_q[step_q.size()-1].ok   = (sticky_err == tbra_pkg::ERR_NONE);
         step_q[step_q.size()-1].code = sticky_err;
         clear_record_state();
      end
      foreach (step_q[j]) converted_q.push_back(step_q[j]);
   endtask

   task automatic send_byte(input logic [7:0] b, input logic last);
      req_valid   <= 1'b1;
      req_in_byte <= b;
      req_in_last <= last;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      adapt_byte(b, last);
      if (!calm && $urandom_range(0, 99) < gap_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 17)) @(posedge clock);
      end
   endtask

   task automatic send_record(input byte_q_type rec);
      foreach (rec[i]) send_byte(rec[i], i == rec.size() - 1);
   endtask

   task automatic settle();
      req_valid <= 1'b0;
      do @(posedge clock); while (converted_q.size() != 0);
      repeat (20) @(posedge clock);
   endtask

   task automatic set_image_size(input logic [9:0] w, input logic [9:0] h);
      csr_wr_en <= 1'b1;
      csr_index <= tbra_pkg::CSR_IMAGE_WIDTH;
      csr_wdata <= w;
      @(posedge clock);
      csr_index <= tbra_pkg::CSR_IMAGE_HEIGHT;
      csr_wdata <= h;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      img_w = w;
      img_h = h;
      @(posedge clock);
   endtask

   task automatic add_char(ref byte_q_type t);
      logic [7:0] lead;
      case ($urandom_range(0, 3))
         0: t.push_back(8'($urandom_range(1, 127)));
         1: begin
            t.push_back(8'($urandom_range(8'hc2, 8'hdf)));
            t.push_back(8'($urandom_range(8'h80, 8'hbf)));
         end
         2: begin
            lead = 8'($urandom_range(8'he0, 8'hef));
            t.push_back(lead);
            if (lead == 8'he0) t.push_back(8'($urandom_range(8'ha0, 8'hbf)));
            else if (lead == 8'hed) t.push_back(8'($urandom_range(8'h80, 8'h9f)));
            else t.push_back(8'($urandom_range(8'h80, 8'hbf)));
            t.push_back(8'($urandom_range(8'h80, 8'hbf)));
         end
         default: begin
            lead = 8'($urandom_range(8'hf0, 8'hf4));
            t.push_back(lead);
            if (lead == 8'hf0) t.push_back(8'($urandom_range(8'h90, 8'hbf)));
            else if (lead == 8'hf4) t.push_back(8'($urandom_range(8'h80, 8'h8f)));
            else t.push_back(8'($urandom_range(8'h80, 8'hbf)));
            t.push_back(8'($urandom_range(8'h80, 8'hbf)));
            t.push_back(8'($urandom_range(8'h80, 8'hbf)));
         end
      endcase
   endtask

   // mostly well-formed records; a share carry one fault of a random kind
   task automatic build_record(output byte_q_type rec);
      byte_q_type  txt;
      logic [15:0] dsc [6];
      logic [15:0] cnt, rsv;
      int unsigned iw, ih, nblk, fault, fb, p;
      rec   = {};
      iw    = img_w;
      ih    = img_h;
      nblk  = ($urandom_range(0, 9) == 0) ? $urandom_range(3, 6) : $urandom_range(0, 1);
      fault = ($urandom_range(0, 99) < 35) ? $urandom_range(1, 9) : 0;
      if (nblk == 0 && fault >= 5) nblk = 1;
      fb    = (nblk == 0) ? 0 : $urandom_range(0, nblk - 1);
      cnt   = 16'(nblk);
      if (fault == 2) cnt = 16'($urandom_range(256, 65535));
      rsv   = (fault == 1) ? 16'($urandom_range(1, 65535)) : 16'd0;
      rec.push_back(cnt[7:0]);
      rec.push_back(cnt[15:8]);
      rec.push_back(rsv[7:0]);
      rec.push_back(rsv[15:8]);
      for (int blk = 0; blk < nblk; blk++) begin
         dsc[0] = (iw == 0) ? 16'd0 : 16'($urandom_range(0, iw - 1));
         dsc[1] = (ih == 0) ? 16'd0 : 16'($urandom_range(0, ih - 1));
         dsc[2] = (iw > dsc[0]) ? 16'($urandom_range(1, iw - dsc[0])) : 16'd1;
         dsc[3] = (ih > dsc[1]) ? 16'($urandom_range(1, ih - dsc[1])) : 16'd1;
         if (fault == 5 && blk == fb) begin
            case ($urandom_range(0, 7))
               0:       dsc[2] = 16'd0;
               1:       dsc[3] = 16'd0;
               2:       dsc[0] = 16'(iw);
               3:       dsc[1] = 16'(ih);
               4:       dsc[2] = 16'(iw - dsc[0] + 1);
               5:       dsc[3] = 16'(ih - dsc[1] + 1);
               6:       dsc[2] = 16'($urandom);
               default: dsc[$urandom_range(0, 1)] = 16'($urandom);
            endcase
         end
         txt = {};
         repeat ($urandom_range(0, 3)) add_char(txt);
         if (fault == 7 && blk == fb) begin
            p = $urandom_range(0, txt.size());
            case ($urandom_range(0, 7))
               0: txt.insert(p, 8'h00);
               1: txt.insert(p, 8'(8'hc0 + $urandom_range(0, 1)));
               2: txt.insert(p, 8'($urandom_range(8'hf5, 8'hff)));
               3: txt.insert(p, 8'($urandom_range(8'h80, 8'hbf)));
               4: begin
                  // surrogate
                  txt.push_back(8'hed);
                  txt.push_back(8'($urandom_range(8'ha0, 8'hbf)));
                  txt.push_back(8'h80);
               end
               5: begin
                  // overlong three-byte form
                  txt.push_back(8'he0);
                  txt.push_back(8'($urandom_range(8'h80, 8'h9f)));
                  txt.push_back(8'h80);
               end
               6: begin
                  txt.push_back(8'hf0);
                  txt.push_back(8'($urandom_range(8'h80, 8'h8f)));
                  txt.push_back(8'h80);
                  txt.push_back(8'h80);
               end
               default: begin
                  // above U+10FFFF
                  txt.push_back(8'hf4);
                  txt.push_back(8'($urandom_range(8'h90, 8'hbf)));
                  txt.push_back(8'h80);
                  txt.push_back(8'h80);
               end
            endcase
         end
         // sequence running past the end of the text
         if (fault == 8 && blk == fb) txt.push_back(8'($urandom_range(8'hc2, 8'hf4)));
         dsc[4] = 16'(txt.size());
         if (fault == 9 && blk == fb) dsc[4] = 16'($urandom_range(txt.size() + 1, 65535));
         dsc[5] = {15'd0, 1'($urandom_range(0, 1))};
         if (fault == 6 && blk == fb) dsc[5] = 16'($urandom_range(2, 65535));
         foreach (dsc[f]) begin
            rec.push_back(dsc[f][7:0]);
            rec.push_back(dsc[f][15:8]);
         end
         foreach (txt[t]) rec.push_back(txt[t]);
      end
      if (fault == 3) begin
         p = $urandom_range(1, rec.size() - 1);
         while (rec.size() > p) rec.delete(rec.size() - 1);
      end
      if (fault == 4) repeat ($urandom_range(1, 3)) rec.push_back(8'($urandom));
      if (fault == 0 && $urandom_range(0, 19) == 0)
         rec[$urandom_range(0, rec.size() - 1)] = 8'($urandom);
   endtask

   task automatic test_header_cases();
      byte_q_type rec;
      rec = {8'h00, 8'h00, 8'h00, 8'h00};
      send_record(rec);
      rec = {8'hff, 8'h00, 8'h00, 8'h00};
      send_record(rec);
      rec = {8'h00, 8'h01, 8'h00, 8'h00};
      send_record(rec);
      rec = {8'h01, 8'h00, 8'h80};
      send_record(rec);
      rec = {8'h02, 8'h00, 8'h00, 8'hff};
      send_record(rec);
      rec = {8'h05};
      send_record(rec);
      rec = {8'h00, 8'h00, 8'h00, 8'h00, 8'haa, 8'h55};
      send_record(rec);
   endtask

   task automatic test_mixed_records();
      byte_q_type rec;
      gap_pct   = 15;
      stall_pct = 8;
      repeat (5) begin
         build_record(rec);
         send_record(rec);
      end
   endtask

   task automatic test_back_pressure();
      byte_q_type rec;
      int         half;
      gap_pct   = 3;
      stall_pct = 30;
      repeat (3) begin
         build_record(rec);
         half = rec.size() / 2;
         for (int i = 0; i < rec.size(); i++) begin
            if (i == half && i != 0) begin
               req_valid <= 1'b0;
               do @(posedge clock); while (converted_q.size() != 0);
            end
            send_byte(rec[i], i == rec.size() - 1);
         end
      end
   endtask

   task automatic test_image_sizes();
      logic [9:0] ws [8];
      logic [9:0] hs [8];
      byte_q_type rec;
      gap_pct   = 12;
      stall_pct = 10;
      ws = '{10'd1, 10'd800, 10'd1, 10'd800, 10'd0, 10'd1023, 10'd1, 10'd1};
      hs = '{10'd1, 10'd800, 10'd800, 10'd1, 10'd1023, 10'd0, 10'd1, 10'd1};
      ws[6] = 10'($urandom_range(1, 800));
      hs[6] = 10'($urandom_range(1, 800));
      ws[7] = 10'($urandom);
      hs[7] = 10'($urandom);
      foreach (ws[i]) begin
         settle();
         set_image_size(ws[i], hs[i]);
         build_record(rec);
         send_record(rec);
      end
   endtask

   task automatic test_streaming_calm();
      byte_q_type rec;
      settle();
      set_image_size(10'($urandom_range(1, 800)), 10'($urandom_range(1, 800)));
      calm = 1'b1;
      repeat (4) begin
         build_record(rec);
         send_record(rec);
      end
   endtask

   always begin
      @(posedge clock);
      if (!calm && $urandom_range(0, 99) < stall_pct) begin
         rsp_stall <= 1'b1;
         repeat ($urandom_range(1, 17)) @(posedge clock);
         rsp_stall <= 1'b0;
      end
   end

   always @(posedge clock) begin : check_page_out
      page_out_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (converted_q.size() == 0) begin
            report_mismatch($sformatf("result %0d arrived with nothing expected", results_seen));
         end else begin
            want = converted_q.pop_front();
            if (rsp_out_byte !== want.data || rsp_byte_present !== want.present
                  || rsp_end_of_record !== want.eor || rsp_record_ok !== want.ok
                  || rsp_error_code !== want.code)
               report_mismatch($sformatf(
                  "result %0d got %02h/%b/%b/%b/%0d expected %02h/%b/%b/%b/%0d", results_seen,
                  rsp_out_byte, rsp_byte_present, rsp_end_of_record, rsp_record_ok,
                  rsp_error_code, want.data, want.present, want.eor, want.ok, want.code));
         end
         results_seen++;
      end
   end

   initial begin
      #3000000;
      $display("** text_block_record_adapter_core: FAILED **");
      $finish;
   end

   initial begin
      clear_record_state();
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_header_cases();
      test_mixed_records();
      test_back_pressure();
      test_image_sizes();
      test_streaming_calm();
      settle();
      if (mismatches == 0) begin
         $display("** text_block_record_adapter_core: PASSED **");
      end else begin
         $display("** text_block_record_adapter_core: FAILED **");
      end
      $finish;
   end

endmodule
